// ----- src/bhd_pkg.sv -----
package bhd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] code_point;
        logic [23:0] utf8_bytes;
        logic        last_char;
    } t_out_beat;

    localparam logic [63:0] MAGIC [8] = '{
        64'h9e3779b97f4a7c15, 64'hbf58476d1ce4e5b9,
        64'h94d049bb133111eb, 64'hff51afd7ed558ccd,
        64'h1337c0debabefeed, 64'hdeadbeefcafeface,
        64'h8badf00dcafebabe, 64'hFEEDFACEDEADCAFE
    };

    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [7:0]  PAD_FILL = 8'h13;
    localparam logic [15:0] CJK_BASE = 16'h4E00;
    localparam logic [15:0] CJK_SPAN = 16'd20991;

    typedef enum logic [3:0] {
        S_IDLE,     // wait for a beat
        S_PUSH,     // push one byte into the assembly word
        S_ROUND_A,  // churn round: xor, rotate-add, load multiplier
        S_RMUL,     // churn round multiply, three 32x32 steps
        S_ROUND_B,  // churn round: shift-xor, add, neighbor xor
        S_PAD,      // push marker or fill byte
        S_FIN_A,    // finalize: load multiplier
        S_FMUL,     // finalize multiply, three 32x32 steps
        S_FIN_B,    // finalize xor and rotate
        S_EMIT      // present one digest character
    } t_state;

    // controller commands to the datapath
    typedef struct packed {
        logic       init;        // reload magic constants
        logic       push;        // push input or pad byte into assembly
        logic       pad_byte;    // 1: push pad byte instead of input byte
        logic       round_a;
        logic       round_b;
        logic [1:0] round;
        logic       mul;         // one partial-product step
        logic [1:0] mul_step;
        logic       fin_a;
        logic       fin_b;
        logic [2:0] fin_idx;
        logic       emit_load;   // register next digest character
        logic [4:0] emit_idx;
    } t_cmd;

    typedef struct packed {
        logic       word_full;   // this push completes a word
        logic       block_zero;  // byte position is 0
    } t_status;

endpackage

// ----- src/bhd_ctrl.sv -----
module bhd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bhd_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  bhd_pkg::t_status    i_status,
    output bhd_pkg::t_cmd       o_cmd
);

    bhd_pkg::t_state r_state, n_state;
    logic [1:0] r_round, n_round;
    logic [1:0] r_mul, n_mul;
    logic [2:0] r_fin, n_fin;
    logic [4:0] r_idx, n_idx;
    logic       r_eom, n_eom;
    logic       r_pad, n_pad;     // in pad phase
    logic       r_ov, n_ov;       // output register full

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhd_pkg::S_IDLE;
            r_round <= '0;
            r_mul   <= '0;
            r_fin   <= '0;
            r_idx   <= '0;
            r_eom   <= 1'b0;
            r_pad   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_mul   <= n_mul;
            r_fin   <= n_fin;
            r_idx   <= n_idx;
            r_eom   <= n_eom;
            r_pad   <= n_pad;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid = r_ov;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_mul   = r_mul;
        n_fin   = r_fin;
        n_idx   = r_idx;
        n_eom   = r_eom;
        n_pad   = r_pad;
        n_ov    = r_ov;
        o_cmd   = '0;
        o_cmd.round   = r_round;
        o_cmd.mul_step = r_mul;
        o_cmd.fin_idx = r_fin;
        o_cmd.emit_idx = r_idx;
        o_in_ready = 1'b0;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        case (r_state)
            bhd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_eom = i_in_data.end_of_message;
                    n_pad = 1'b0;
                    if (i_in_data.byte_present) n_state = bhd_pkg::S_PUSH;
                    else if (i_in_data.end_of_message) begin
                        n_state = bhd_pkg::S_PAD;
                        n_pad   = 1'b1;
                    end
                end
            end
            bhd_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
                o_cmd.pad_byte = r_pad;
                n_round = '0;
                if (i_status.word_full) n_state = bhd_pkg::S_ROUND_A;
                else if (r_eom) begin
                    n_state = bhd_pkg::S_PAD;
                    n_pad   = 1'b1;
                end else n_state = bhd_pkg::S_IDLE;
            end
            bhd_pkg::S_PAD: begin
                // a pad byte, pushed like a data byte
                o_cmd.push = 1'b1;
                o_cmd.pad_byte = 1'b1;
                n_round = '0;
                if (i_status.word_full) n_state = bhd_pkg::S_ROUND_A;
            end
            bhd_pkg::S_ROUND_A: begin
                o_cmd.round_a = 1'b1;
                n_mul   = '0;
                n_state = bhd_pkg::S_RMUL;
            end
            bhd_pkg::S_RMUL: begin
                o_cmd.mul = 1'b1;
                n_mul = r_mul + 2'd1;
                if (r_mul == 2'd2) n_state = bhd_pkg::S_ROUND_B;
            end
            bhd_pkg::S_ROUND_B: begin
                o_cmd.round_b = 1'b1;
                n_round = r_round + 2'd1;
                if (r_round != 2'd3) n_state = bhd_pkg::S_ROUND_A;
                else if (!r_eom) n_state = bhd_pkg::S_IDLE;
                else if (!r_pad) begin
                    n_state = bhd_pkg::S_PAD;
                    n_pad   = 1'b1;
                end else if (i_status.block_zero) begin
                    n_state = bhd_pkg::S_FIN_A;
                    n_fin   = '0;
                end else n_state = bhd_pkg::S_PAD;
            end
            bhd_pkg::S_FIN_A: begin
                o_cmd.fin_a = 1'b1;
                n_mul   = '0;
                n_state = bhd_pkg::S_FMUL;
            end
            bhd_pkg::S_FMUL: begin
                o_cmd.mul = 1'b1;
                n_mul = r_mul + 2'd1;
                if (r_mul == 2'd2) n_state = bhd_pkg::S_FIN_B;
            end
            bhd_pkg::S_FIN_B: begin
                o_cmd.fin_b = 1'b1;
                n_fin = r_fin + 3'd1;
                if (r_fin == 3'd7) begin
                    n_state = bhd_pkg::S_EMIT;
                    n_idx   = '0;
                end else n_state = bhd_pkg::S_FIN_A;
            end
            bhd_pkg::S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.emit_load = 1'b1;
                    n_ov  = 1'b1;
                    n_idx = r_idx + 5'd1;
                    if (r_idx == 5'd31) begin
                        o_cmd.init = 1'b1;
                        n_eom   = 1'b0;
                        n_pad   = 1'b0;
                        n_state = bhd_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = bhd_pkg::S_IDLE;
        endcase
    end

endmodule

// ----- src/bhd_dp.sv -----
module bhd_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,      // input beat accepted
    input  bhd_pkg::t_in_beat   i_in_data,
    input  bhd_pkg::t_cmd       i_cmd,
    output bhd_pkg::t_status    o_status,
    output bhd_pkg::t_out_beat  o_out_data
);

    logic [63:0] r_h [8];
    logic [63:0] n_h [8];
    logic [63:0] r_word, n_word;
    logic [5:0]  r_pos, n_pos;
    logic [7:0]  r_byte;
    logic        r_marked, n_marked;
    logic [63:0] r_ma, r_mb, r_b, r_prod;
    logic        r_full;
    bhd_pkg::t_out_beat r_out;

    logic [2:0]  ia, ib, in1, if3;
    logic [63:0] a0, b0, a1, b1, a2, fx, nbr;
    logic [31:0] m_x, m_y;
    logic [63:0] m_p;
    logic [7:0]  pb;
    logic [15:0] chunk, red, cp;
    logic [16:0] dif;
    logic [63:0] hw;

    assign ia  = {1'b0, i_cmd.round};
    assign ib  = 3'd7 - ia;
    assign in1 = ia + 3'd1;
    assign if3 = i_cmd.fin_idx + 3'd3;

    // round part A: a = h[r]^w^salt; b += rotl(a,19); then a *= magic0
    assign a0 = r_h[ia] ^ r_word ^ bhd_pkg::MAGIC[ia + 3'd4];
    assign b0 = r_h[ib] + {a0[44:0], a0[63:45]};
    // part B on registered a (product) and b
    assign b1 = r_b ^ (r_prod >> 13);
    assign a1 = r_prod + b1;
    // in the last round the neighbor is the word just updated as b
    assign nbr = (in1 == ib) ? b1 : r_h[in1];
    assign a2 = a1 ^ (nbr + bhd_pkg::MAGIC[ia]);
    assign fx = r_h[i_cmd.fin_idx] ^ r_prod;

    // low 64 bits of r_ma * r_mb: lo*lo, then lo*hi and hi*lo into the top half
    always_comb begin
        case (i_cmd.mul_step)
            2'd0: begin
                m_x = r_ma[31:0];
                m_y = r_mb[31:0];
            end
            2'd1: begin
                m_x = r_ma[31:0];
                m_y = r_mb[63:32];
            end
            default: begin
                m_x = r_ma[63:32];
                m_y = r_mb[31:0];
            end
        endcase
        m_p = m_x * m_y;
    end

    assign pb = r_marked ? bhd_pkg::PAD_FILL : bhd_pkg::PAD_MARK;

    // chunk mod 20991: chunk < 65536 < 4*20991, up to three subtractions
    assign hw    = r_h[i_cmd.emit_idx[4:2]];
    assign chunk = hw[{i_cmd.emit_idx[1:0], 4'd0} +: 16];
    always_comb begin
        red = chunk;
        if (red >= bhd_pkg::CJK_SPAN) red = red - bhd_pkg::CJK_SPAN;
        dif = {1'b0, red} - {1'b0, bhd_pkg::CJK_SPAN};
        if (!dif[16]) red = dif[15:0];
        dif = {1'b0, red} - {1'b0, bhd_pkg::CJK_SPAN};
        if (!dif[16]) red = dif[15:0];
    end
    assign cp = bhd_pkg::CJK_BASE + red;

    always_comb begin
        n_h      = r_h;
        n_word   = r_word;
        n_pos    = r_pos;
        n_marked = r_marked;
        if (i_cmd.push) begin
            n_word = r_word | ({56'd0, i_cmd.pad_byte ? pb : r_byte}
                     << {r_pos[2:0], 3'd0});
            n_pos  = r_pos + 6'd1;
            if (i_cmd.pad_byte) n_marked = 1'b1;
        end
        if (i_cmd.round_b) begin
            n_h[ia] = a2;
            n_h[ib] = b1;
            if (i_cmd.round == 2'd3) n_word = '0;
        end
        if (i_cmd.fin_b) n_h[i_cmd.fin_idx] = {fx[32:0], fx[63:33]};
        if (i_cmd.init) begin
            for (int i = 0; i < 8; i++) n_h[i] = bhd_pkg::MAGIC[i];
            n_word = '0;
            n_pos = '0;
            n_marked = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= bhd_pkg::MAGIC[i];
            r_word   <= '0;
            r_pos    <= '0;
            r_marked <= 1'b0;
            r_full   <= 1'b0;
        end else begin
            r_h      <= n_h;
            r_word   <= n_word;
            r_pos    <= n_pos;
            r_marked <= n_marked;
            r_full   <= i_cmd.push && (r_pos[2:0] == 3'd7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_byte <= i_in_data.data_byte;
        if (i_cmd.round_a) begin
            r_b  <= b0;
            r_ma <= a0;
            r_mb <= bhd_pkg::MAGIC[0];
        end
        if (i_cmd.fin_a) begin
            r_ma <= r_h[if3];
            r_mb <= bhd_pkg::MAGIC[3'd7 - i_cmd.fin_idx];
        end
        if (i_cmd.mul) begin
            if (i_cmd.mul_step == 2'd0) r_prod <= m_p;
            else r_prod[63:32] <= r_prod[63:32] + m_p[31:0];
        end
        if (i_cmd.emit_load) begin
            r_out.code_point <= cp;
            r_out.utf8_bytes <= {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
            r_out.last_char  <= (i_cmd.emit_idx == 5'd31);
        end
    end

    // word_full is evaluated combinationally while pushing
    assign o_status.word_full  = i_cmd.push && (r_pos[2:0] == 3'd7);
    assign o_status.block_zero = (r_pos == 6'd0) && !r_full;
    assign o_out_data = r_out;

endmodule

// ----- src/byte_hash_512_cjk_digest.sv -----
// Byte-serial 512-bit hash with a 32-character CJK digest. One beat carries
// an optional message byte and an end-of-message flag. A beat with neither
// is ignored; a byte beat is pushed into a 64-bit word, and a byte that
// completes the word starts four churn rounds (each a setup, three steps
// through one 32x32 multiplier, and an update). A beat with end pads the
// 64-byte block with a marker and fill bytes, churning each completed word,
// finalizes the eight state words, then emits 32 result beats, one per
// cycle when the sink is ready; the state returns to its initial constants
// after the last one.
module byte_hash_512_cjk_digest (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bhd_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bhd_pkg::t_out_beat  o_out_data
);

    bhd_pkg::t_cmd    cmd;
    bhd_pkg::t_status status;

    bhd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bhd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_in_valid && o_in_ready),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

    // a pending result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed");

    // no input accepted while digest characters are still being produced
    a_no_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_load && !o_out_data.last_char |-> !o_in_ready)
        else $error("input accepted during emit");

    // datapath commands are mutually exclusive
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.push, cmd.round_a, cmd.mul, cmd.round_b, cmd.fin_a,
                    cmd.fin_b, cmd.emit_load}) <= 1)
        else $error("conflicting datapath commands");

endmodule

// ----- tb/sv/bhd_checker.sv -----
module bhd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  bhd_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bhd_pkg::t_out_beat i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0]        hw [8];
    logic [63:0]        asm_word;
    logic [5:0]         blk_pos;
    bhd_pkg::t_out_beat digest_q [$];

    function automatic logic [63:0] rol(input logic [63:0] x, input int s);
        return (x << s) | (x >> (64 - s));
    endfunction

    task automatic load_magic();
        for (int i = 0; i < 8; i++) hw[i] = bhd_pkg::MAGIC[i];
        asm_word = '0;
        blk_pos  = '0;
    endtask

    task automatic churn(input logic [63:0] w);
        logic [63:0] a, b;
        for (int r = 0; r < 4; r++) begin
            a = hw[r];
            b = hw[7-r];
            a ^= w ^ bhd_pkg::MAGIC[r+4];
            b += rol(a, 19);
            a *= bhd_pkg::MAGIC[0];
            b ^= a >> 13;
            a += b;
            hw[r] = a;
            hw[7-r] = b;
            hw[r] ^= hw[(r+1) & 7] + bhd_pkg::MAGIC[r];
        end
    endtask

    task automatic feed_byte(input logic [7:0] v);
        logic [2:0] lane;
        lane = blk_pos[2:0];
        asm_word |= 64'(v) << (8 * lane);
        blk_pos++;
        if (lane == 3'd7) begin
            churn(asm_word);
            asm_word = '0;
        end
    endtask

    task automatic close_message();
        logic [15:0] chunk, cp;
        bhd_pkg::t_out_beat ob;
        feed_byte(bhd_pkg::PAD_MARK);
        while (blk_pos != 0) feed_byte(bhd_pkg::PAD_FILL);
        for (int i = 0; i < 8; i++) begin
            hw[i] ^= hw[(i+3) & 7] * bhd_pkg::MAGIC[7-i];
            hw[i] = rol(hw[i], 31);
        end
        for (int k = 0; k < 32; k++) begin
            chunk = hw[k >> 2][16*(k & 3) +: 16];
            cp = bhd_pkg::CJK_BASE + 16'(32'(chunk) % 32'(bhd_pkg::CJK_SPAN));
            ob.code_point = cp;
            ob.utf8_bytes = {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
            ob.last_char  = (k == 31);
            digest_q.push_back(ob);
        end
        load_magic();
    endtask

    initial load_magic();

    always @(posedge i_clk) begin
        bhd_pkg::t_out_beat exp_b;
        if (!i_rst_n) begin
            load_magic();
            digest_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected digest beat %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_b = digest_q.pop_front();
                    if (exp_b !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp cp=%h u8=%h last=%b got cp=%h u8=%h last=%b",
                                exp_b.code_point, exp_b.utf8_bytes, exp_b.last_char,
                                i_out_data.code_point, i_out_data.utf8_bytes,
                                i_out_data.last_char);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.byte_present) feed_byte(i_in_data.data_byte);
                if (i_in_data.end_of_message) close_message();
            end
            o_pending <= digest_q.size();
        end
    end
endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    bhd_pkg::t_in_beat  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    bhd_pkg::t_out_beat out_data;
    int                 fail_count;
    int                 pending;

    // idle odds in percent, per phase
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        recv_hold = 1'b0;   // long receiver hold-off
    int        stall_cycles = 0;
    bit        hold_req = 1'b0;
    int        stall_len = 0;

    always #10 clk = ~clk;

    byte_hash_512_cjk_digest u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    bhd_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Receiver: random ready, or a counted hold-off when requested.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_req && stall_cycles < stall_len) begin
            out_ready <= 1'b0;
            stall_cycles <= stall_cycles + 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles without any accepted beat.
    int quiet = 0;
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one beat; valid holds until accepted and drops only when idling.
    task automatic send_beat(input logic [7:0] b, input bit pres, input bit eom);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, byte_present: pres, end_of_message: eom};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // A message of n random bytes, optionally with the end on the last byte.
    task automatic send_message(input int n, input bit end_on_byte);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom), 1'b1, end_on_byte && (i == n - 1));
        if (!end_on_byte || n == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 58;

        // empty message: end alone
        send_beat(8'hFF, 1'b0, 1'b1);
        // no byte, no end: must be ignored
        send_beat(8'hA5, 1'b0, 1'b0);
        // extremes of the byte, end together with byte
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        // marker fills the block: 63 bytes then end
        send_message(63, 1'b0);
        // full word boundary
        send_message(8, 1'b1);
        drain();

        // long receiver hold-off while the sender keeps offering
        stall_cycles = 0;
        stall_len = 400;
        hold_req = 1'b1;
        send_message(3, 1'b1);
        send_message(5, 1'b0);
        in_valid <= 1'b0;
        @(negedge clk);
        while (stall_cycles < stall_len) @(negedge clk);
        hold_req = 1'b0;
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 58 : 0;
            recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 9 : 0;
            for (int m = 0; m < 4; m++) begin
                if ($urandom_range(9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
                send_message($urandom_range(14), $urandom_range(1));
            end
            // sender pause until every digest beat has come
            drain();
        end

        drain();
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
src/bhd_pkg.sv
src/bhd_ctrl.sv
src/bhd_dp.sv
src/byte_hash_512_cjk_digest.sv
tb/sv/bhd_checker.sv
tb/sv/testbench.sv
